/* hdl/rpt_pkg.sv */
// Shared widths, register indexes, trig types and series reciprocals for the relative pose core.
package rpt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;

	// pipeline widths
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int TRIG_W = 32;
	localparam int PROD_W = DIFF_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int FRAC_W = 30;
	localparam int RND_W  = SUM_W - FRAC_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Y     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_ANGLE = 2'd2;

	// Q30 trig constants
	localparam logic [30:0] Q_ONE  = 31'h4000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [3:0] LAST_COS_TERM = 4'd4;
	localparam logic [3:0] LAST_SIN_TERM = 4'd8;

	typedef enum logic [2:0] {
		TRIG_IDLE,
		TRIG_X,
		TRIG_X2,
		TRIG_MUL,
		TRIG_DIV,
		TRIG_SIN,
		TRIG_FIN
	} trig_state_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	// Divisors, cosine terms first: 90, 56, 30, 12, 2, then sine terms: 72, 42, 20, 6.
	// Each is replaced by ceil(2^s / k) and a right shift by s, with s = 30 + ceil(log2 k),
	// which is exact for every dividend below 2^30.
	function automatic logic [31:0] series_magic(input logic [3:0] term);
		logic [31:0] m;
		unique case (term)
			4'd0:    m = 32'd1527099484;
			4'd1:    m = 32'd1227133514;
			4'd2:    m = 32'd1145324613;
			4'd3:    m = 32'd1431655766;
			4'd4:    m = 32'd1073741824;
			4'd5:    m = 32'd1908874354;
			4'd6:    m = 32'd1636178018;
			4'd7:    m = 32'd1717986919;
			4'd8:    m = 32'd1431655766;
			default: m = 32'd1073741824;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] series_shift(input logic [3:0] term);
		logic [5:0] s;
		unique case (term)
			4'd0:    s = 6'd37;
			4'd1:    s = 6'd36;
			4'd2:    s = 6'd35;
			4'd3:    s = 6'd34;
			4'd4:    s = 6'd31;
			4'd5:    s = 6'd37;
			4'd6:    s = 6'd36;
			4'd7:    s = 6'd35;
			4'd8:    s = 6'd33;
			default: s = 6'd31;
		endcase
		return s;
	endfunction

endpackage

/* hdl/rpt_trig.sv */
// Sequential sine and cosine unit for the reference heading, one shared multiplier.
module rpt_trig (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rpt_pkg::ANGLE_WIDTH-1:0]   angle,
	output logic                              busy,
	output rpt_pkg::trig_t                    trig
);

	localparam int SHIFT_W = 32 - rpt_pkg::ANGLE_WIDTH;
	localparam logic signed [rpt_pkg::TRIG_W-1:0] UNIT_Q30 = rpt_pkg::TRIG_W'(rpt_pkg::Q_ONE);

	rpt_pkg::trig_state_t state_q, state_nxt;

	logic [1:0]  quad_q;
	logic        swap_q;
	logic [30:0] q_q;
	logic [29:0] x_q;
	logic [29:0] x2_q;
	logic [30:0] t_q;
	logic [3:0]  term_q;
	logic [29:0] num_q;
	logic [30:0] cos_raw_q;
	logic [30:0] sin_raw_q;
	rpt_pkg::trig_t trig_q;

	logic [31:0] turn;
	logic [29:0] turn_rem;
	logic [30:0] mul_a;
	logic [31:0] mul_b;
	logic [62:0] prod;
	logic [31:0] magic;
	logic [5:0]  rshift;
	logic [29:0] quo;
	logic signed [rpt_pkg::TRIG_W-1:0] s_sel, c_sel;

	assign turn     = {angle, {SHIFT_W{1'b0}}};
	assign turn_rem = turn[29:0];

	// floor divide by the series constant: multiply by its rounded-up reciprocal
	assign magic  = rpt_pkg::series_magic(term_q);
	assign rshift = rpt_pkg::series_shift(term_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			rpt_pkg::TRIG_X: begin
				mul_a = q_q;
				mul_b = rpt_pkg::PI_Q30;
			end
			rpt_pkg::TRIG_X2: begin
				mul_a = {1'b0, x_q};
				mul_b = {2'b00, x_q};
			end
			rpt_pkg::TRIG_MUL: begin
				mul_a = t_q;
				mul_b = {2'b00, x2_q};
			end
			rpt_pkg::TRIG_DIV: begin
				mul_a = {1'b0, num_q};
				mul_b = magic;
			end
			rpt_pkg::TRIG_SIN: begin
				mul_a = t_q;
				mul_b = {2'b00, x_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 63'(mul_a) * 63'(mul_b);
	assign quo  = 30'(prod >> rshift);

	// undo the octant swap
	assign s_sel = swap_q ? rpt_pkg::TRIG_W'(cos_raw_q) : rpt_pkg::TRIG_W'(sin_raw_q);
	assign c_sel = swap_q ? rpt_pkg::TRIG_W'(sin_raw_q) : rpt_pkg::TRIG_W'(cos_raw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpt_pkg::TRIG_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rpt_pkg::TRIG_IDLE: if (start) state_nxt = rpt_pkg::TRIG_X;
			rpt_pkg::TRIG_X:    state_nxt = rpt_pkg::TRIG_X2;
			rpt_pkg::TRIG_X2:   state_nxt = rpt_pkg::TRIG_MUL;
			rpt_pkg::TRIG_MUL:  state_nxt = rpt_pkg::TRIG_DIV;
			rpt_pkg::TRIG_DIV: begin
				state_nxt = (term_q == rpt_pkg::LAST_SIN_TERM) ?
					rpt_pkg::TRIG_SIN : rpt_pkg::TRIG_MUL;
			end
			rpt_pkg::TRIG_SIN:  state_nxt = rpt_pkg::TRIG_FIN;
			rpt_pkg::TRIG_FIN:  state_nxt = rpt_pkg::TRIG_IDLE;
			default:            state_nxt = rpt_pkg::TRIG_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rpt_pkg::TRIG_IDLE: begin
				if (start) begin
					quad_q <= turn[31:30];
					swap_q <= turn_rem[29];
					q_q    <= turn_rem[29] ? 31'(rpt_pkg::Q_ONE - {1'b0, turn_rem})
					                       : {1'b0, turn_rem};
				end
			end
			rpt_pkg::TRIG_X: begin
				x_q <= prod[60:31];
			end
			rpt_pkg::TRIG_X2: begin
				x2_q   <= prod[59:30];
				t_q    <= rpt_pkg::Q_ONE;
				term_q <= '0;
			end
			rpt_pkg::TRIG_MUL: begin
				num_q <= prod[59:30];
			end
			rpt_pkg::TRIG_DIV: begin
				term_q <= term_q + 4'd1;
				if (term_q == rpt_pkg::LAST_COS_TERM) begin
					cos_raw_q <= rpt_pkg::Q_ONE - {1'b0, quo};
					t_q       <= rpt_pkg::Q_ONE;
				end else begin
					t_q <= rpt_pkg::Q_ONE - {1'b0, quo};
				end
			end
			rpt_pkg::TRIG_SIN: begin
				sin_raw_q <= prod[60:30];
			end
			default: begin
			end
		endcase
	end

	// published result; reset value is the zero heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q.sin_v <= '0;
			trig_q.cos_v <= rpt_pkg::TRIG_W'(rpt_pkg::Q_ONE);
		end else if (state_q == rpt_pkg::TRIG_FIN) begin
			unique case (quad_q)
				2'd0: begin
					trig_q.sin_v <= s_sel;
					trig_q.cos_v <= c_sel;
				end
				2'd1: begin
					trig_q.sin_v <= c_sel;
					trig_q.cos_v <= -s_sel;
				end
				2'd2: begin
					trig_q.sin_v <= -s_sel;
					trig_q.cos_v <= -c_sel;
				end
				default: begin
					trig_q.sin_v <= -c_sel;
					trig_q.cos_v <= s_sel;
				end
			endcase
		end
	end

	assign busy = state_q != rpt_pkg::TRIG_IDLE;
	assign trig = trig_q;

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpt_pkg::TRIG_FIN |=>
			(trig_q.sin_v <= UNIT_Q30) && (trig_q.sin_v >= -UNIT_Q30))
		else $error("sine left the Q30 unit range");

endmodule

/* hdl/rpt_rotate.sv */
// Four-stage rotation pipeline: difference, products, rounded sums, saturation.
module rpt_rotate (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  target_x,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  target_y,
	input  logic signed [rpt_pkg::ANGLE_WIDTH-1:0]  target_angle,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  ref_x,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  ref_y,
	input  logic signed [rpt_pkg::ANGLE_WIDTH-1:0]  ref_angle,
	input  rpt_pkg::trig_t                          trig,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [rpt_pkg::COORD_WIDTH-1:0]  rel_x,
	output logic signed [rpt_pkg::COORD_WIDTH-1:0]  rel_y,
	output logic signed [rpt_pkg::ANGLE_WIDTH-1:0]  rel_angle,
	output logic                                    overflow
);

	localparam int CW = rpt_pkg::COORD_WIDTH;
	localparam int AW = rpt_pkg::ANGLE_WIDTH;
	localparam int UP_W = rpt_pkg::RND_W - CW + 1;
	localparam logic signed [rpt_pkg::SUM_W-1:0] HALF_LSB =
		rpt_pkg::SUM_W'(1) <<< (rpt_pkg::FRAC_W - 1);
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [rpt_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [AW-1:0]              ang_s1, ang_s2, ang_s3;
	logic signed [rpt_pkg::PROD_W-1:0] cdx_s2, sdy_s2, sdx_s2, cdy_s2;
	logic signed [rpt_pkg::RND_W-1:0]  rx_s3, ry_s3;
	logic signed [CW-1:0]              rx_s4, ry_s4;
	logic signed [AW-1:0]              ang_s4;
	logic                              ovf_s4;

	logic signed [rpt_pkg::SUM_W-1:0]  sum_x, sum_y;
	logic [UP_W-1:0]                   up_x, up_y;
	logic                              fit_x, fit_y;
	logic signed [CW-1:0]              sat_x, sat_y;

	// whole pipe advances unless the output beat is held
	assign adv      = !v_s4 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sum_x = rpt_pkg::SUM_W'(cdx_s2) - rpt_pkg::SUM_W'(sdy_s2) + HALF_LSB;
	assign sum_y = rpt_pkg::SUM_W'(sdx_s2) + rpt_pkg::SUM_W'(cdy_s2) + HALF_LSB;

	assign up_x  = rx_s3[rpt_pkg::RND_W-1:CW-1];
	assign up_y  = ry_s3[rpt_pkg::RND_W-1:CW-1];
	assign fit_x = (&up_x) || !(|up_x);
	assign fit_y = (&up_y) || !(|up_y);
	assign sat_x = fit_x ? rx_s3[CW-1:0] : (rx_s3[rpt_pkg::RND_W-1] ? C_MIN : C_MAX);
	assign sat_y = fit_y ? ry_s3[CW-1:0] : (ry_s3[rpt_pkg::RND_W-1] ? C_MIN : C_MAX);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: position and heading differences
			dx_s1  <= rpt_pkg::DIFF_W'(target_x) - rpt_pkg::DIFF_W'(ref_x);
			dy_s1  <= rpt_pkg::DIFF_W'(target_y) - rpt_pkg::DIFF_W'(ref_y);
			ang_s1 <= target_angle - ref_angle;
			// s2: rotation products
			cdx_s2 <= dx_s1 * trig.cos_v;
			sdy_s2 <= dy_s1 * trig.sin_v;
			sdx_s2 <= dx_s1 * trig.sin_v;
			cdy_s2 <= dy_s1 * trig.cos_v;
			ang_s2 <= ang_s1;
			// s3: sum, round half up, floor shift out the Q30 fraction
			rx_s3  <= sum_x[rpt_pkg::SUM_W-1:rpt_pkg::FRAC_W];
			ry_s3  <= sum_y[rpt_pkg::SUM_W-1:rpt_pkg::FRAC_W];
			ang_s3 <= ang_s2;
			// s4: clamp to coordinate range
			rx_s4  <= sat_x;
			ry_s4  <= sat_y;
			ang_s4 <= ang_s3;
			ovf_s4 <= !fit_x || !fit_y;
		end
	end

	assign out_valid = v_s4;
	assign rel_x     = rx_s4;
	assign rel_y     = ry_s4;
	assign rel_angle = ang_s4;
	assign overflow  = ovf_s4;

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2 == $past(v_s1))
		else $error("valid bit lost or duplicated between s1 and s2");

	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ovf_s4) |->
			(rx_s4 == C_MAX || rx_s4 == C_MIN || ry_s4 == C_MAX || ry_s4 == C_MIN))
		else $error("overflow flagged without a clamped coordinate");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v_s3 == $past(v_s3))
		else $error("pipe moved while output beat was held");

endmodule

/* hdl/relative_pose_transform_core.sv */
// Relative pose core: reference registers, trig unit and rotation pipeline.
// A target beat passes the difference, product, sum and clamp registers before it appears on the rel channel.
// Throughput: one beat per cycle while the rel side keeps taking results and the trig unit is idle.
// A write to ref_angle starts the trig unit (two multiplier steps for each of 9 series terms,
// plus angle, square, sine and publish steps); meanwhile cfg_ready and target_stall hold.
// Reset: asynchronous, clears references to zero (sin 0, cos 1) and empties the pipe.
module relative_pose_transform_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rpt_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [rpt_pkg::COORD_WIDTH-1:0]         cfg_data,
	// target pose channel
	input  logic                                    target_valid,
	output logic                                    target_stall,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  target_x,
	input  logic signed [rpt_pkg::COORD_WIDTH-1:0]  target_y,
	input  logic signed [rpt_pkg::ANGLE_WIDTH-1:0]  target_angle,
	// relative pose channel
	output logic                                    rel_valid,
	input  logic                                    rel_stall,
	output logic signed [rpt_pkg::COORD_WIDTH-1:0]  rel_x,
	output logic signed [rpt_pkg::COORD_WIDTH-1:0]  rel_y,
	output logic signed [rpt_pkg::ANGLE_WIDTH-1:0]  rel_angle,
	output logic                                    overflow
);

	logic signed [rpt_pkg::COORD_WIDTH-1:0] ref_x_q;
	logic signed [rpt_pkg::COORD_WIDTH-1:0] ref_y_q;
	logic signed [rpt_pkg::ANGLE_WIDTH-1:0] ref_angle_q;

	logic           cfg_we;
	logic           angle_we;
	logic           trig_busy;
	logic           rot_stall;
	rpt_pkg::trig_t trig;

	// a write beat is refused while the trig unit runs
	assign cfg_ready = !trig_busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign angle_we  = cfg_we && (cfg_index == rpt_pkg::REG_REF_ANGLE);

	// unknown indexes drop the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q     <= '0;
			ref_y_q     <= '0;
			ref_angle_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == rpt_pkg::REG_REF_X) begin
				ref_x_q <= cfg_data;
			end
			if (cfg_index == rpt_pkg::REG_REF_Y) begin
				ref_y_q <= cfg_data;
			end
			if (cfg_index == rpt_pkg::REG_REF_ANGLE) begin
				ref_angle_q <= cfg_data[rpt_pkg::ANGLE_WIDTH-1:0];
			end
		end
	end

	// sin and cos of the reference heading, recomputed on each heading write
	rpt_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (angle_we),
		.angle  (cfg_data[rpt_pkg::ANGLE_WIDTH-1:0]),
		.busy   (trig_busy),
		.trig   (trig)
	);

	// hold off target beats until sin and cos are settled
	assign target_stall = rot_stall || trig_busy;

	rpt_rotate u_rotate (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (target_valid && !trig_busy),
		.in_stall     (rot_stall),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_angle (target_angle),
		.ref_x        (ref_x_q),
		.ref_y        (ref_y_q),
		.ref_angle    (ref_angle_q),
		.trig         (trig),
		.out_valid    (rel_valid),
		.out_stall    (rel_stall),
		.rel_x        (rel_x),
		.rel_y        (rel_y),
		.rel_angle    (rel_angle),
		.overflow     (overflow)
	);

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		trig_busy |-> (target_stall && !cfg_ready))
		else $error("beat admitted while trig unit busy");

	a_angle_starts: assert property (@(posedge clk) disable iff (!arst_n)
		angle_we |=> trig_busy)
		else $error("heading write did not start the trig unit");

endmodule
